FILE: hdl/three_axis_zero_offset_calibrator_top_assert.svh
// Assertion macros shared by the calibrator checker.
`ifndef THREE_AXIS_ZERO_OFFSET_CALIBRATOR_TOP_ASSERT_SVH
`define THREE_AXIS_ZERO_OFFSET_CALIBRATOR_TOP_ASSERT_SVH

// Condition c must hold in the same cycle as a.
`define TAZOC_ASSERT_SAME(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
        else $error("calibrator check failed: same-cycle implication");

// Condition c must hold in the cycle after a.
`define TAZOC_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
        else $error("calibrator check failed: next-cycle implication");

`endif

FILE: hdl/tazoc_pkg.sv
// ----------------------------------------------------------------------------
// tazoc_pkg
// Shared constants, codes and lane control types of the three-axis
// zero-offset calibrator.
// ----------------------------------------------------------------------------
package tazoc_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int TIME_BITS       = 32;
    localparam int WIN_BITS        = 16;
    localparam int THR_BITS        = 16;
    localparam int NUM_AXES        = 3;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 16;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_BUSY = 2'd1,
        ST_DONE = 2'd2,
        ST_FAIL = 2'd3
    } cal_status_t;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ALLOW_FAIL = 2'd2;

    typedef struct packed {
        logic clear;
        logic acc;
        logic div_start;
    } lane_cmd_t;

    typedef struct packed {
        logic noisy;
        logic div_busy;
    } lane_stat_t;

endpackage

FILE: hdl/tazoc_lane.sv
// ----------------------------------------------------------------------------
// tazoc_lane
// One axis: sum and sum of squares, a pipelined variance test and a
// restoring divider that forms the truncated mean.
// ----------------------------------------------------------------------------
module tazoc_lane #(
    parameter int SAMPLE_BITS = tazoc_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = tazoc_pkg::COUNT_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tazoc_pkg::lane_cmd_t                 cmd,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic [COUNT_BITS-1:0]                count,
    input  logic [tazoc_pkg::THR_BITS-1:0]       threshold,
    output tazoc_pkg::lane_stat_t                stat,
    output logic signed [SAMPLE_BITS-1:0]        offset
);
    import tazoc_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1 + COUNT_BITS;
    localparam int A_W    = SQ_W + COUNT_BITS;
    localparam int B_W    = 2 * SUM_W;
    localparam int NN_W   = 2 * COUNT_BITS;
    localparam int T2_W   = 2 * THR_BITS;
    localparam int R_W    = T2_W + NN_W;
    localparam int CMP_W  = (B_W > R_W) ? B_W : R_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);

    logic signed [SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]           sqsum_reg;
    logic [SAMPLE_BITS-1:0]    smag;
    logic [2*SAMPLE_BITS-1:0]  sq;
    logic [SUM_W-1:0]          sum_mag;

    logic [A_W-1:0]            a_reg;
    logic [B_W-1:0]            b_reg;
    logic [NN_W-1:0]           nn1_reg;
    logic [T2_W-1:0]           thr2_reg;
    logic [B_W-1:0]            lhs_reg;
    logic [R_W-1:0]            rhs_reg;
    logic                      noisy_reg;

    logic [DCNT_W-1:0]         dcnt_reg;
    logic [COUNT_BITS-1:0]     rem_reg;
    logic [SUM_W-1:0]          quo_reg;
    logic                      neg_reg;
    logic signed [SAMPLE_BITS-1:0] offset_reg;
    logic [COUNT_BITS:0]       rem_sh;
    logic [COUNT_BITS:0]       diff;
    logic                      ge;
    logic [COUNT_BITS-1:0]     rem_next;
    logic [SUM_W-1:0]          quo_next;
    logic [SAMPLE_BITS-1:0]    qs;

    assign smag    = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
    assign sq      = smag * smag;
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            sum_reg   <= '0;
            sqsum_reg <= '0;
        end else if (cmd.acc) begin
            sum_reg   <= sum_reg + SUM_W'(sample);
            sqsum_reg <= sqsum_reg + SQ_W'(sq);
        end
    end

    // Free-running test: n*sumsq - sum^2 > thr^2 * n*(n-1), formed through
    // the product registers, then lhs/rhs, then noisy_reg, once the accumulators settle.
    always_ff @(posedge aclk) begin
        a_reg     <= A_W'(count) * A_W'(sqsum_reg);
        b_reg     <= B_W'(sum_mag) * B_W'(sum_mag);
        nn1_reg   <= NN_W'(count) * NN_W'(count - 1'b1);
        thr2_reg  <= T2_W'(threshold) * T2_W'(threshold);
        lhs_reg   <= B_W'(a_reg) - b_reg;
        rhs_reg   <= R_W'(thr2_reg) * R_W'(nn1_reg);
        noisy_reg <= CMP_W'(lhs_reg) > CMP_W'(rhs_reg);
    end

    assign rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
    assign ge       = rem_sh >= {1'b0, count};
    assign diff     = rem_sh - {1'b0, count};
    assign rem_next = ge ? diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
    assign quo_next = {quo_reg[SUM_W-2:0], ge};
    assign qs       = quo_next[SAMPLE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_start) begin
            dcnt_reg <= DCNT_W'(SUM_W);
        end else if (dcnt_reg != '0) begin
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= sum_mag;
            neg_reg <= sum_reg[SUM_W-1];
        end else if (dcnt_reg != '0) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (dcnt_reg == DCNT_W'(1)) begin
                if (count == '0) begin
                    offset_reg <= '0;
                end else begin
                    offset_reg <= neg_reg ? ('0 - qs) : qs;
                end
            end
        end
    end

    assign stat.noisy    = noisy_reg;
    assign stat.div_busy = (dcnt_reg != '0);
    assign offset        = offset_reg;

endmodule

FILE: hdl/three_axis_zero_offset_calibrator_top.sv
// ----------------------------------------------------------------------------
// three_axis_zero_offset_calibrator_top
// Zero-offset calibration of a three-axis sensor with a deviation check.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// s_axis   | in        | tuser: req_type; tdata: time_ms, sample_x, sample_y, sample_z
// m_axis   | out       | tuser: status, restarted; tdata: zero_x, zero_y, zero_z
// cfg      | in        | cfg_index selects window_ms, stddev_threshold, allow_failure
//
// A word is accepted in S_IDLE or S_EMIT and applied to the axis lanes in
// S_STEP; the result is registered while the next word is accepted.
// At the end of the window the block waits in S_CHECK for the variance
// pipeline, and a passed check then waits in S_DIV for the bit-serial mean
// divider in each lane. Reset is synchronous and needs no clearing pass;
// a stalled output holds the block after its next word.
module three_axis_zero_offset_calibrator_top #(
    parameter int SAMPLE_BITS = tazoc_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = tazoc_pkg::COUNT_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // time_ms, sample_x, sample_y, sample_z, zero fill
    input  logic [((tazoc_pkg::TIME_BITS + 3*SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // req_type
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // zero_x, zero_y, zero_z, zero fill
    output logic [((3*SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // status, restarted
    output logic [2:0]                            m_axis_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tazoc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [tazoc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import tazoc_pkg::*;

    localparam int OUT_DATA_W = ((3*SAMPLE_BITS + 7) / 8) * 8;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_STEP  = 5'b00010,
        S_CHECK = 5'b00100,
        S_DIV   = 5'b01000,
        S_EMIT  = 5'b10000
    } fsm_t;

    localparam logic [1:0] CHECK_WAIT = 2'd3;

    fsm_t                     state_reg, state_next;
    cal_status_t              status_reg, status_next;
    logic [TIME_BITS-1:0]     wstart_reg, wstart_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic                     restarted_reg, restarted_next;
    logic [1:0]               chk_reg, chk_next;
    logic [WIN_BITS-1:0]      window_reg;
    logic [THR_BITS-1:0]      thr_reg;
    logic                     allow_reg;

    logic                     req_reg;
    logic [TIME_BITS-1:0]     time_reg;
    logic signed [SAMPLE_BITS-1:0] samp_reg [NUM_AXES];

    logic                     m_valid_reg;
    logic [OUT_DATA_W-1:0]    m_data_reg;
    logic [2:0]               m_user_reg;

    lane_cmd_t                lane_cmd;
    lane_stat_t               lane_stat [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] lane_off [NUM_AXES];
    logic                     noisy_any;
    logic                     div_busy_any;
    logic                     out_free;
    logic                     in_acc;
    logic                     emit;
    logic [3*SAMPLE_BITS-1:0] out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WIN_BITS'(2000);
            thr_reg    <= THR_BITS'(64);
            allow_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WINDOW:     window_reg <= cfg_data[WIN_BITS-1:0];
                REG_THRESHOLD:  thr_reg    <= cfg_data[THR_BITS-1:0];
                REG_ALLOW_FAIL: allow_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) || ((state_reg == S_EMIT) && out_free);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign emit          = (state_reg == S_EMIT) && out_free;

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            req_reg  <= s_axis_tuser;
            time_reg <= s_axis_tdata[TIME_BITS-1:0];
            for (int i = 0; i < NUM_AXES; i++) begin
                samp_reg[i] <= s_axis_tdata[TIME_BITS + i*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_AXES; g++) begin : g_lane
            tazoc_lane #(
                .SAMPLE_BITS(SAMPLE_BITS),
                .COUNT_BITS (COUNT_BITS)
            ) u_lane (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cmd      (lane_cmd),
                .sample   (samp_reg[g]),
                .count    (count_reg),
                .threshold(thr_reg),
                .stat     (lane_stat[g]),
                .offset   (lane_off[g])
            );
        end
    endgenerate

    // Merge what the lanes report.
    always_comb begin
        noisy_any    = 1'b0;
        div_busy_any = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            noisy_any    = noisy_any | lane_stat[i].noisy;
            div_busy_any = div_busy_any | lane_stat[i].div_busy;
        end
    end

    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        wstart_next    = wstart_reg;
        count_next     = count_reg;
        restarted_next = restarted_reg;
        chk_next       = chk_reg;
        lane_cmd       = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    state_next = S_STEP;
                end
            end
            S_STEP: begin
                restarted_next = 1'b0;
                state_next     = S_EMIT;
                if (req_reg) begin
                    status_next    = ST_BUSY;
                    wstart_next    = time_reg;
                    count_next     = '0;
                    lane_cmd.clear = 1'b1;
                end else if (status_reg == ST_BUSY) begin
                    if (count_reg != '1) begin
                        lane_cmd.acc = 1'b1;
                        count_next   = count_reg + 1'b1;
                    end
                    if ((time_reg - wstart_reg) > TIME_BITS'(window_reg)) begin
                        chk_next   = '0;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (chk_reg != CHECK_WAIT) begin
                    chk_next = chk_reg + 1'b1;
                end else if (noisy_any) begin
                    state_next = S_EMIT;
                    if (!allow_reg) begin
                        wstart_next    = time_reg;
                        count_next     = '0;
                        lane_cmd.clear = 1'b1;
                        restarted_next = 1'b1;
                    end else begin
                        status_next = ST_FAIL;
                    end
                end else begin
                    lane_cmd.div_start = 1'b1;
                    state_next         = S_DIV;
                end
            end
            S_DIV: begin
                if (!div_busy_any) begin
                    status_next = ST_DONE;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit) begin
                    state_next = in_acc ? S_STEP : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            status_reg    <= ST_IDLE;
            wstart_reg    <= '0;
            count_reg     <= '0;
            restarted_reg <= 1'b0;
            chk_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            wstart_reg    <= wstart_next;
            count_reg     <= count_next;
            restarted_reg <= restarted_next;
            chk_reg       <= chk_next;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            out_data[i*SAMPLE_BITS +: SAMPLE_BITS] =
                (status_reg == ST_DONE) ? lane_off[i] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= OUT_DATA_W'(out_data);
            m_user_reg <= {restarted_reg, status_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

FILE: hdl/tazoc_checker.sv
// ----------------------------------------------------------------------------
// tazoc_checker
// Port-level checks of the calibrator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "three_axis_zero_offset_calibrator_top_assert.svh"

module tazoc_checker #(
    parameter int SAMPLE_BITS = tazoc_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = tazoc_pkg::COUNT_BITS_DEF
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic [((tazoc_pkg::TIME_BITS + 3*SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input logic                                  s_axis_tuser,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [((3*SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input logic [2:0]                            m_axis_tuser,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready,
    input logic [tazoc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input logic [tazoc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import tazoc_pkg::*;

    // A stalled result word holds.
    `TAZOC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Offsets are only reported once the calibration is done.
    `TAZOC_ASSERT_SAME(a_zero_unless_done, aclk, aresetn,
        m_axis_tvalid && (m_axis_tuser[1:0] != ST_DONE), m_axis_tdata == '0)

    // A deviation restart keeps the calibration in progress.
    `TAZOC_ASSERT_SAME(a_restart_busy, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == ST_BUSY)

    // Each accepted word is worked on in S_STEP before the next is taken.
    `TAZOC_ASSERT_NEXT(a_one_word_at_a_time, aclk, aresetn,
        s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind three_axis_zero_offset_calibrator_top tazoc_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_tazoc_checker (.*);
